### rtl/eoti_pkg.sv
// ============================================================================
// Earth orientation table package
// Shared constants, codes and transaction types for the table lookup and
// interpolation core.
// ============================================================================
package eoti_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int DAY_W    = 17;
  localparam int FRAC_W   = 16;
  localparam int TAI_W    = 8;
  localparam int KEY_W    = DAY_W + TAI_W;
  localparam int LANE_W   = 32;
  localparam int LANES    = 8;
  localparam int LANE_IW  = $clog2(LANES);
  localparam int ROW_W    = LANE_W * LANES;
  localparam int RAD_W    = 48;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 2;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_NEXT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Lane order inside a stored row, low lane first
  localparam logic [LANE_IW-1:0] LANE_POLE_X  = 3'd0;
  localparam logic [LANE_IW-1:0] LANE_POLE_Y  = 3'd1;
  localparam logic [LANE_IW-1:0] LANE_UT1     = 3'd2;
  localparam logic [LANE_IW-1:0] LANE_LOD     = 3'd3;
  localparam logic [LANE_IW-1:0] LANE_NUT_LON = 3'd4;
  localparam logic [LANE_IW-1:0] LANE_NUT_OBL = 3'd5;
  localparam logic [LANE_IW-1:0] LANE_POLE_DX = 3'd6;
  localparam logic [LANE_IW-1:0] LANE_POLE_DY = 3'd7;

  // Arcsecond to radian factor: floor(pi * 2^62) / 162000, in Q40 of
  // the 2^-24 arcsecond to 2^-48 radian conversion.
  localparam logic [46:0] RAD_K    = 47'd89432338988606;
  localparam logic [31:0] RAD_K_LO = RAD_K[31:0];
  localparam logic [14:0] RAD_K_HI = RAD_K[46:32];
  localparam logic [63:0] RAD_RND  = 64'h0000_0080_0000_0000;

  // One lane of work entering the interpolation pipeline
  typedef struct packed {
    logic               valid;
    logic [LANE_IW-1:0] lane;
    logic [LANE_W-1:0]  a;
    logic [LANE_W-1:0]  b;
    logic [FRAC_W-1:0]  frac;
    logic               interp;
  } eoti_lane_in_t;

  // One finished lane leaving the pipeline
  typedef struct packed {
    logic               valid;
    logic [LANE_IW-1:0] lane;
    logic [RAD_W-1:0]   rad;
    logic [LANE_W-1:0]  val;
  } eoti_lane_out_t;

  // Result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RAD_W-1:0]    pole_x;
    logic [RAD_W-1:0]    pole_y;
    logic [LANE_W-1:0]   ut1;
    logic [LANE_W-1:0]   lod;
    logic [RAD_W-1:0]    nut_lon;
    logic [RAD_W-1:0]    nut_obl;
    logic [RAD_W-1:0]    pole_dx;
    logic [RAD_W-1:0]    pole_dy;
    logic [TAI_W-1:0]    tai;
  } eoti_result_t;

endpackage

### rtl/eoti_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module eoti_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/eoti_lane_pipe.sv
// ============================================================================
// Lane interpolation and radian scaling pipeline
// Seven-stage pipeline that blends one 32-bit lane toward the next row and
// scales the result from arcseconds to radians. One lane may enter per cycle.
// ============================================================================
module eoti_lane_pipe (
  input  logic                    clk,
  input  logic                    rst_n,
  input  eoti_pkg::eoti_lane_in_t lane_in,
  output eoti_pkg::eoti_lane_out_t lane_out
);

  // Stage valid bits and lane tags
  logic [6:0] vld_r;
  logic [6:0] vld_nxt;
  logic [eoti_pkg::LANE_IW-1:0] lane1_r, lane2_r, lane3_r, lane4_r, lane5_r, lane6_r, lane7_r;

  // Stage payload
  logic signed [31:0] a1_r;
  logic signed [49:0] prod1_r;
  logic signed [50:0] sum2_r;
  logic signed [31:0] v3_r, v4_r, v5_r, v6_r, v7_r;
  logic        [31:0] mag4_r, mag5_r;
  logic               neg4_r, neg5_r, neg6_r;
  logic        [63:0] plo5_r;
  logic        [46:0] t6_r;
  logic        [47:0] rad7_r;

  // Combinational stage logic
  logic signed [32:0] diff;
  logic signed [16:0] frac_s;
  logic signed [49:0] prod;
  logic signed [50:0] a_sh;
  logic signed [50:0] sum;
  logic signed [50:0] rnd_sum;
  logic signed [50:0] rnd_add;
  logic        [31:0] mag;
  logic        [63:0] plo;
  logic        [46:0] t;
  logic        [47:0] r48;
  logic        [47:0] rad;

  // Stage 1: difference times fraction; a zero difference keeps the row value
  assign diff   = lane_in.interp ?
                  ($signed({lane_in.b[31], lane_in.b}) - $signed({lane_in.a[31], lane_in.a})) :
                  33'sd0;
  assign frac_s = $signed({1'b0, lane_in.frac});
  assign prod   = diff * frac_s;

  // Stage 2: add the row value scaled to 2^-40 units
  assign a_sh = $signed({{3{a1_r[31]}}, a1_r, 16'b0});
  assign sum  = a_sh + $signed({prod1_r[49], prod1_r});

  // Stage 3: round half away from zero back to 2^-24 units
  assign rnd_add = sum2_r[50] ? 51'sd32767 : 51'sd32768;
  assign rnd_sum = sum2_r + rnd_add;

  // Stage 4: magnitude
  assign mag = v3_r[31] ? (~v3_r + 32'd1) : v3_r;

  // Stage 5: low partial product with rounding term
  assign plo = 64'(mag4_r) * 64'(RAD_K_LO_C) + eoti_pkg::RAD_RND;

  // Stage 6: high partial product plus carry-in from the low one
  assign t = 47'(mag5_r) * 47'(eoti_pkg::RAD_K_HI) + 47'(plo5_r[63:32]);

  // Stage 7: drop the guard bits and restore the sign
  assign r48 = {9'b0, t6_r[46:8]};
  assign rad = neg6_r ? (~r48 + 48'd1) : r48;

  localparam logic [31:0] RAD_K_LO_C = eoti_pkg::RAD_K_LO;

  // Valid chain
  always_comb begin
    vld_nxt = {vld_r[5:0], lane_in.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    lane1_r <= lane_in.lane;
    a1_r    <= $signed(lane_in.a);
    prod1_r <= prod;

    lane2_r <= lane1_r;
    sum2_r  <= sum;

    lane3_r <= lane2_r;
    v3_r    <= rnd_sum[47:16];

    lane4_r <= lane3_r;
    v4_r    <= v3_r;
    mag4_r  <= mag;
    neg4_r  <= v3_r[31];

    lane5_r <= lane4_r;
    v5_r    <= v4_r;
    mag5_r  <= mag4_r;
    neg5_r  <= neg4_r;
    plo5_r  <= plo;

    lane6_r <= lane5_r;
    v6_r    <= v5_r;
    neg6_r  <= neg5_r;
    t6_r    <= t;

    lane7_r <= lane6_r;
    v7_r    <= v6_r;
    rad7_r  <= rad;
  end

  assign lane_out.valid = vld_r[6];
  assign lane_out.lane  = lane7_r;
  assign lane_out.rad   = rad7_r;
  assign lane_out.val   = v7_r;

endmodule

### rtl/earth_orientation_table_interp_core.sv
// ============================================================================
// Earth orientation table lookup and interpolation core
// Stores daily orientation rows, finds a query day by linear search and
// returns the row, or the row interpolated toward the next one, with angles
// converted to radians.
// ============================================================================
// Usage: append, clear and unused actions go from accept through the push
// state to the result. A query walks the key memory one row per cycle
// through its single read port; a match is followed by two row fetches,
// eight lanes through the seven-stage interpolation pipeline and the push
// state that posts the result, and a day that is absent is reported once
// every stored row has been compared, up to 4096 rows in a full table. One
// transaction is worked on at a time; a finished result sits in the output
// register while the next input transaction is accepted. The user must
// write interp_mode through the cfg port only while the core is idle; the
// core does not enforce it; the table needs no clearing pass after reset.
module earth_orientation_table_interp_core (
  input  logic        clk,
  input  logic        rst_n,

  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_interp_mode,

  // Input transaction channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [16:0] in_mjd_day,
  input  logic [15:0] in_day_fraction,
  input  logic signed [31:0] in_pole_x_arcsec,
  input  logic signed [31:0] in_pole_y_arcsec,
  input  logic signed [31:0] in_ut1_minus_utc_in,
  input  logic signed [31:0] in_day_length_in,
  input  logic signed [31:0] in_nut_lon_arcsec,
  input  logic signed [31:0] in_nut_obl_arcsec,
  input  logic signed [31:0] in_pole_dx_arcsec,
  input  logic signed [31:0] in_pole_dy_arcsec,
  input  logic [7:0]  in_tai_minus_utc_in,

  // Result transaction channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [47:0] out_pole_x_rad,
  output logic signed [47:0] out_pole_y_rad,
  output logic signed [31:0] out_ut1_minus_utc_out,
  output logic signed [31:0] out_day_length_out,
  output logic signed [47:0] out_nut_lon_rad,
  output logic signed [47:0] out_nut_obl_rad,
  output logic signed [47:0] out_pole_dx_rad,
  output logic signed [47:0] out_pole_dy_rad,
  output logic [7:0]  out_tai_minus_utc_out
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_FETCH_A = 3'd2;
  localparam logic [2:0] S_FETCH_B = 3'd3;
  localparam logic [2:0] S_LOAD    = 3'd4;
  localparam logic [2:0] S_LANES   = 3'd5;
  localparam logic [2:0] S_PUSH    = 3'd6;

  localparam logic [eoti_pkg::CNT_W-1:0] DEPTH_C = eoti_pkg::CNT_W'(eoti_pkg::TABLE_DEPTH);
  localparam logic [eoti_pkg::CNT_W-1:0] ONE_C   = eoti_pkg::CNT_W'(1);

  // Control registers
  logic [2:0]                    state_r, state_nxt;
  logic [eoti_pkg::CNT_W-1:0]    row_count_r, row_count_nxt;
  logic                          mode_r, mode_nxt;
  logic [eoti_pkg::CNT_W-1:0]    scan_r, scan_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [eoti_pkg::LANE_IW:0]    lane_cnt_r, lane_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Payload registers
  logic [eoti_pkg::ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [eoti_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic                          interp_r, interp_nxt;
  logic [eoti_pkg::DAY_W-1:0]    day_r, day_nxt;
  logic [eoti_pkg::FRAC_W-1:0]   frac_r, frac_nxt;
  logic [eoti_pkg::ROW_W-1:0]    row_a_r, row_a_nxt;
  logic [eoti_pkg::ROW_W-1:0]    row_b_r, row_b_nxt;
  eoti_pkg::eoti_result_t        res_r, res_nxt;
  eoti_pkg::eoti_result_t        out_r, out_nxt;

  // Memory ports
  logic                          row_we;
  logic [eoti_pkg::ADDR_W-1:0]   row_waddr;
  logic [eoti_pkg::KEY_W-1:0]    key_wdata, key_q;
  logic [eoti_pkg::ROW_W-1:0]    val_wdata, val_q;
  logic [eoti_pkg::ADDR_W-1:0]   key_raddr, val_raddr;

  // Misc
  logic                          in_acc;
  logic                          out_free;
  logic                          issue;
  logic                          has_next;
  logic [eoti_pkg::LANE_IW-1:0]  lane_sel;
  eoti_pkg::eoti_lane_in_t       lane_in;
  eoti_pkg::eoti_lane_out_t      lane_out;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Row storage: keys in one memory, the eight value lanes in another
  assign row_we    = in_acc && (in_action == eoti_pkg::ACT_APPEND) && (row_count_r < DEPTH_C);
  assign row_waddr = row_count_r[eoti_pkg::ADDR_W-1:0];
  assign key_wdata = {in_tai_minus_utc_in, in_mjd_day};
  assign val_wdata = {in_pole_dy_arcsec, in_pole_dx_arcsec, in_nut_obl_arcsec,
                      in_nut_lon_arcsec, in_day_length_in, in_ut1_minus_utc_in,
                      in_pole_y_arcsec, in_pole_x_arcsec};
  assign key_raddr = scan_r[eoti_pkg::ADDR_W-1:0];
  assign val_raddr = (state_r == S_FETCH_B) ? (idx_r + eoti_pkg::ADDR_W'(1)) : idx_r;

  eoti_ram #(
    .DATA_W (eoti_pkg::KEY_W),
    .DEPTH  (eoti_pkg::TABLE_DEPTH),
    .ADDR_W (eoti_pkg::ADDR_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_q)
  );

  eoti_ram #(
    .DATA_W (eoti_pkg::ROW_W),
    .DEPTH  (eoti_pkg::TABLE_DEPTH),
    .ADDR_W (eoti_pkg::ADDR_W)
  ) u_val_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_q)
  );

  // Lane feed into the interpolation pipeline
  assign lane_sel       = lane_cnt_r[eoti_pkg::LANE_IW-1:0];
  assign lane_in.valid  = (state_r == S_LANES) && !lane_cnt_r[eoti_pkg::LANE_IW];
  assign lane_in.lane   = lane_sel;
  assign lane_in.a      = row_a_r[lane_sel*eoti_pkg::LANE_W +: eoti_pkg::LANE_W];
  assign lane_in.b      = row_b_r[lane_sel*eoti_pkg::LANE_W +: eoti_pkg::LANE_W];
  assign lane_in.frac   = frac_r;
  assign lane_in.interp = interp_r;

  eoti_lane_pipe u_lane_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .lane_in  (lane_in),
    .lane_out (lane_out)
  );

  // Search helpers
  assign issue    = (scan_r < row_count_r);
  assign has_next = (({1'b0, rd_addr_r} + ONE_C) < row_count_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    mode_nxt      = mode_r;
    scan_nxt      = scan_r;
    rd_vld_nxt    = rd_vld_r;
    lane_cnt_nxt  = lane_cnt_r;
    out_valid_nxt = out_valid_r;
    rd_addr_nxt   = rd_addr_r;
    idx_nxt       = idx_r;
    interp_nxt    = interp_r;
    day_nxt       = day_r;
    frac_nxt      = frac_r;
    row_a_nxt     = row_a_r;
    row_b_nxt     = row_b_r;
    res_nxt       = res_r;
    out_nxt       = out_r;

    // Configuration register write
    if (cfg_valid) begin
      mode_nxt = cfg_interp_mode;
    end

    // Result register drains when taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          case (in_action)
            eoti_pkg::ACT_APPEND: begin
              if (row_count_r < DEPTH_C) begin
                row_count_nxt = row_count_r + ONE_C;
              end else begin
                res_nxt.status = eoti_pkg::ST_FULL;
              end
              state_nxt = S_PUSH;
            end
            eoti_pkg::ACT_CLEAR: begin
              row_count_nxt = '0;
              state_nxt     = S_PUSH;
            end
            eoti_pkg::ACT_QUERY: begin
              scan_nxt   = '0;
              rd_vld_nxt = 1'b0;
              day_nxt    = in_mjd_day;
              frac_nxt   = in_day_fraction;
              state_nxt  = S_SEARCH;
            end
            default: begin
              state_nxt = S_PUSH;
            end
          endcase
        end
      end

      // One key read issued per cycle; compare the one returned
      S_SEARCH: begin
        if (rd_vld_r && (key_q[eoti_pkg::DAY_W-1:0] == day_r)) begin
          idx_nxt     = rd_addr_r;
          res_nxt.tai = key_q[eoti_pkg::KEY_W-1:eoti_pkg::DAY_W];
          interp_nxt  = mode_r && has_next;
          if (mode_r && !has_next) begin
            res_nxt.status = eoti_pkg::ST_NO_NEXT;
          end
          state_nxt = S_FETCH_A;
        end else if (!issue && !rd_vld_r) begin
          res_nxt.status = eoti_pkg::ST_NOT_FOUND;
          state_nxt      = S_PUSH;
        end else begin
          rd_vld_nxt  = issue;
          rd_addr_nxt = scan_r[eoti_pkg::ADDR_W-1:0];
          if (issue) begin
            scan_nxt = scan_r + ONE_C;
          end
        end
      end

      // Matched row read is in flight
      S_FETCH_A: begin
        state_nxt = S_FETCH_B;
      end

      // Capture the matched row; the following row is in flight
      S_FETCH_B: begin
        row_a_nxt = val_q;
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        row_b_nxt    = val_q;
        lane_cnt_nxt = '0;
        state_nxt    = S_LANES;
      end

      // Feed eight lanes and collect them as they leave the pipeline
      S_LANES: begin
        if (!lane_cnt_r[eoti_pkg::LANE_IW]) begin
          lane_cnt_nxt = lane_cnt_r + (eoti_pkg::LANE_IW + 1)'(1);
        end
        if (lane_out.valid) begin
          case (lane_out.lane)
            eoti_pkg::LANE_POLE_X:  res_nxt.pole_x  = lane_out.rad;
            eoti_pkg::LANE_POLE_Y:  res_nxt.pole_y  = lane_out.rad;
            eoti_pkg::LANE_UT1:     res_nxt.ut1     = lane_out.val;
            eoti_pkg::LANE_LOD:     res_nxt.lod     = lane_out.val;
            eoti_pkg::LANE_NUT_LON: res_nxt.nut_lon = lane_out.rad;
            eoti_pkg::LANE_NUT_OBL: res_nxt.nut_obl = lane_out.rad;
            eoti_pkg::LANE_POLE_DX: res_nxt.pole_dx = lane_out.rad;
            eoti_pkg::LANE_POLE_DY: res_nxt.pole_dy = lane_out.rad;
            default:                res_nxt = res_r;
          endcase
          if (lane_out.lane == eoti_pkg::LANE_POLE_DY) begin
            state_nxt = S_PUSH;
          end
        end
      end

      // Post the result once the output register is free
      S_PUSH: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= '0;
      mode_r      <= 1'b0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      lane_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      mode_r      <= mode_nxt;
      scan_r      <= scan_nxt;
      rd_vld_r    <= rd_vld_nxt;
      lane_cnt_r  <= lane_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    idx_r     <= idx_nxt;
    interp_r  <= interp_nxt;
    day_r     <= day_nxt;
    frac_r    <= frac_nxt;
    row_a_r   <= row_a_nxt;
    row_b_r   <= row_b_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Result ports
  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_pole_x_rad        = out_r.pole_x;
  assign out_pole_y_rad        = out_r.pole_y;
  assign out_ut1_minus_utc_out = out_r.ut1;
  assign out_day_length_out    = out_r.lod;
  assign out_nut_lon_rad       = out_r.nut_lon;
  assign out_nut_obl_rad       = out_r.nut_obl;
  assign out_pole_dx_rad       = out_r.pole_dx;
  assign out_pole_dy_rad       = out_r.pole_dy;
  assign out_tai_minus_utc_out = out_r.tai;

`ifndef NO_ASSERTIONS
  // The row count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= DEPTH_C)
    else $error("row count exceeds table depth");

  // An append into a table with room grows the row count by one.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == eoti_pkg::ACT_APPEND) && (row_count_r < DEPTH_C))
    |=> (row_count_r == $past(row_count_r) + ONE_C))
    else $error("append did not advance the row count");

  // Lanes only leave the pipeline while a query collects them.
  a_lanes_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    lane_out.valid |-> (state_r == S_LANES))
    else $error("lane result outside of lane collection");

  // A missing day reports all-zero values.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == eoti_pkg::ST_NOT_FOUND))
    |-> ((out_r.tai == '0) && (out_r.pole_x == '0) && (out_r.ut1 == '0)))
    else $error("not-found result carries data");
`endif

endmodule
